// ===== design/rtt_pkg.sv =====
`default_nettype none

package rtt_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int SEQ_W    = 63;
    localparam int PKT_W    = 20;
    localparam int TIME_W   = 63;
    localparam int SLOT_W   = 7;
    localparam int TMO_W    = 48;
    localparam int RETRY_W  = 4;

    // Table size default
    localparam int TABLE_SLOTS_DEF = 64;

    // Register reset values
    localparam logic [TMO_W-1:0]   TIMEOUT_RST     = 48'd1000000000;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

    // APB register map (64-bit registers, byte address 8*i)
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam logic REG_TIMEOUT     = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SAVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_num;
        logic [PKT_W-1:0]  packet_index;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] slot_request;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [PKT_W-1:0]  packet_index_res;
        logic              gave_up;
    } rsp_t;

    // One table row
    typedef struct packed {
        logic               valid;
        logic [SEQ_W-1:0]   seq;
        logic [PKT_W-1:0]   packet;
        logic [TIME_W-1:0]  deadline;
        logic [RETRY_W-1:0] retries;
    } tbl_row_t;

    // Per-field write enables
    typedef struct packed {
        logic valid;
        logic seq;
        logic packet;
        logic deadline;
        logic retries;
    } tbl_we_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // now + timeout, saturating at the top of the time range
    function automatic logic [TIME_W-1:0] sat_deadline(input logic [TIME_W-1:0] now,
                                                       input logic [TMO_W-1:0]  tmo);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - TMO_W){1'b0}}, tmo};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/rtt_cmp.sv =====
`default_nettype none

// Shared 63-bit magnitude comparator
module rtt_cmp (
    input  wire logic [rtt_pkg::TIME_W-1:0] a,
    input  wire logic [rtt_pkg::TIME_W-1:0] b,
    output logic                            eq,
    output logic                            lt
);

    assign eq = (a == b);
    assign lt = (a < b);

endmodule

`default_nettype wire

// ===== design/rtt_table.sv =====
`default_nettype none

// Request table: one read port, one write port, per-field write enables
module rtt_table #(
    parameter int TABLE_SLOTS = rtt_pkg::TABLE_SLOTS_DEF,
    localparam int IDXW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [IDXW-1:0]      rd_addr,
    output rtt_pkg::tbl_row_t         rd_row,
    input  wire rtt_pkg::tbl_we_t     we,
    input  wire logic [IDXW-1:0]      wr_addr,
    input  wire rtt_pkg::tbl_row_t    wr_row
);

    logic                          valid_mem    [TABLE_SLOTS];
    logic [rtt_pkg::SEQ_W-1:0]     seq_mem      [TABLE_SLOTS];
    logic [rtt_pkg::PKT_W-1:0]     packet_mem   [TABLE_SLOTS];
    logic [rtt_pkg::TIME_W-1:0]    deadline_mem [TABLE_SLOTS];
    logic [rtt_pkg::RETRY_W-1:0]   retries_mem  [TABLE_SLOTS];

    rtt_pkg::tbl_row_t rd_row_reg;

    // Writes
    always_ff @(posedge aclk) begin
        if (we.valid) begin
            valid_mem[wr_addr] <= wr_row.valid;
        end
        if (we.seq) begin
            seq_mem[wr_addr] <= wr_row.seq;
        end
        if (we.packet) begin
            packet_mem[wr_addr] <= wr_row.packet;
        end
        if (we.deadline) begin
            deadline_mem[wr_addr] <= wr_row.deadline;
        end
        if (we.retries) begin
            retries_mem[wr_addr] <= wr_row.retries;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg.valid    <= valid_mem[rd_addr];
            rd_row_reg.seq      <= seq_mem[rd_addr];
            rd_row_reg.packet   <= packet_mem[rd_addr];
            rd_row_reg.deadline <= deadline_mem[rd_addr];
            rd_row_reg.retries  <= retries_mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

// ===== design/rtt_ctrl.sv =====
`default_nettype none

// Sequencer: clears the table after reset, then sweeps it once per request
module rtt_ctrl #(
    parameter int TABLE_SLOTS = rtt_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rtt_pkg::req_t                 s_data,
    input  wire logic [rtt_pkg::TMO_W-1:0]     timeout,
    input  wire logic [rtt_pkg::RETRY_W-1:0]   retry_limit,
    input  wire logic                          out_free,
    output logic                               res_load,
    output rtt_pkg::rsp_t                      res
);

    localparam int IDXW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SW     = (IDXW + 1 > rtt_pkg::SLOT_W) ? IDXW + 1 : rtt_pkg::SLOT_W;
    localparam int SLOTW  = rtt_pkg::SLOT_W;
    localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(TABLE_SLOTS - 1);
    localparam logic [IDXW:0]   SLOTS_CNT = (IDXW + 1)'(TABLE_SLOTS);
    localparam logic [SW-1:0]   SLOTS_SW  = SW'(TABLE_SLOTS);

    rtt_pkg::state_t state_reg, state_next;

    logic [IDXW:0]   cnt_reg, cnt_next;
    logic            dv_reg, dv_next;
    logic [IDXW-1:0] didx_reg, didx_next;

    rtt_pkg::req_t   item_reg, item_next;
    logic            req_ok_reg, req_ok_next;
    logic [IDXW-1:0] req_idx_reg, req_idx_next;
    logic            req_free_reg, req_free_next;

    logic                          found_reg, found_next;
    logic [IDXW-1:0]               found_idx_reg, found_idx_next;
    logic [rtt_pkg::PKT_W-1:0]     found_pkt_reg, found_pkt_next;
    logic                          free_found_reg, free_found_next;
    logic [IDXW-1:0]               free_idx_reg, free_idx_next;

    logic                          best_found_reg, best_found_next;
    logic [IDXW-1:0]               best_idx_reg, best_idx_next;
    logic [rtt_pkg::TIME_W-1:0]    best_dl_reg, best_dl_next;
    logic [rtt_pkg::PKT_W-1:0]     best_pkt_reg, best_pkt_next;
    logic [rtt_pkg::RETRY_W-1:0]   best_ret_reg, best_ret_next;

    logic                          rd_en;
    logic [IDXW-1:0]               rd_addr;
    rtt_pkg::tbl_row_t             rd_row;
    rtt_pkg::tbl_we_t              we;
    logic [IDXW-1:0]               wr_addr;
    rtt_pkg::tbl_row_t             wr_row;

    logic [rtt_pkg::TIME_W-1:0]    cmp_a, cmp_b;
    logic                          cmp_eq, cmp_lt;
    logic                          is_check;
    logic                          accept;
    logic [SW-1:0]                 req_ext;
    logic [IDXW-1:0]               save_idx;
    logic                          save_ok;
    logic [IDXW:0]                 slot_found, slot_best, slot_save;
    logic [rtt_pkg::TIME_W-1:0]    new_dl;

    assign is_check = (item_reg.kind == rtt_pkg::KIND_CHECK);
    assign accept   = s_valid && s_ready;
    assign req_ext  = SW'(s_data.slot_request);
    assign new_dl   = rtt_pkg::sat_deadline(item_reg.now, timeout);

    // Save target: lowest free slot or the requested one
    assign save_idx = (item_reg.slot_request == '0) ? free_idx_reg : req_idx_reg;
    assign save_ok  = !found_reg &&
                      ((item_reg.slot_request == '0) ? free_found_reg
                                                     : (req_ok_reg && req_free_reg));

    assign slot_found = {1'b0, found_idx_reg} + (IDXW + 1)'(1);
    assign slot_best  = {1'b0, best_idx_reg} + (IDXW + 1)'(1);
    assign slot_save  = {1'b0, save_idx} + (IDXW + 1)'(1);

    // Shared comparator operands: key or deadline during the sweep,
    // now against the earliest deadline at the end
    always_comb begin
        if (state_reg == rtt_pkg::ST_FINISH) begin
            cmp_a = item_reg.now;
            cmp_b = best_dl_reg;
        end else if (is_check) begin
            cmp_a = rd_row.deadline;
            cmp_b = best_dl_reg;
        end else begin
            cmp_a = rd_row.seq;
            cmp_b = item_reg.seq_num;
        end
    end

    rtt_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq),
        .lt (cmp_lt)
    );

    rtt_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_row  (wr_row)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtt_pkg::ST_CLEAR: begin
                if (cnt_reg[IDXW-1:0] == LAST_IDX) begin
                    state_next = rtt_pkg::ST_IDLE;
                end
            end
            rtt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rtt_pkg::ST_SCAN;
                end
            end
            rtt_pkg::ST_SCAN: begin
                if (dv_reg && didx_reg == LAST_IDX) begin
                    state_next = rtt_pkg::ST_FINISH;
                end
            end
            rtt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rtt_pkg::ST_IDLE;
                end
            end
            default: state_next = rtt_pkg::ST_CLEAR;
        endcase
    end

    // Outputs: ready, table access, result
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = cnt_reg[IDXW-1:0];
        we       = '0;
        wr_addr  = cnt_reg[IDXW-1:0];
        wr_row   = '0;
        res_load = 1'b0;
        res      = '0;
        unique case (state_reg)
            rtt_pkg::ST_CLEAR: begin
                we.valid = 1'b1;
            end
            rtt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            rtt_pkg::ST_SCAN: begin
                rd_en = (cnt_reg < SLOTS_CNT);
            end
            rtt_pkg::ST_FINISH: begin
                if (out_free) begin
                    res_load = 1'b1;
                    unique case (item_reg.kind)
                        rtt_pkg::KIND_SAVE: begin
                            if (save_ok) begin
                                we              = '1;
                                wr_addr         = save_idx;
                                wr_row.valid    = 1'b1;
                                wr_row.seq      = item_reg.seq_num;
                                wr_row.packet   = item_reg.packet_index;
                                wr_row.deadline = new_dl;
                                wr_row.retries  = retry_limit;
                                res.hit         = 1'b1;
                                res.slot        = SLOTW'(slot_save);
                            end
                        end
                        rtt_pkg::KIND_MATCH: begin
                            if (found_reg) begin
                                we.valid             = 1'b1;
                                wr_addr              = found_idx_reg;
                                res.hit              = 1'b1;
                                res.slot             = SLOTW'(slot_found);
                                res.packet_index_res = found_pkt_reg;
                            end
                        end
                        rtt_pkg::KIND_CHECK: begin
                            if (best_found_reg && !cmp_lt) begin
                                wr_addr              = best_idx_reg;
                                res.hit              = 1'b1;
                                res.slot             = SLOTW'(slot_best);
                                res.packet_index_res = best_pkt_reg;
                                if (best_ret_reg == '0) begin
                                    we.valid    = 1'b1;
                                    res.gave_up = 1'b1;
                                end else begin
                                    we.deadline     = 1'b1;
                                    we.retries      = 1'b1;
                                    wr_row.deadline = new_dl;
                                    wr_row.retries  = best_ret_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        cnt_next        = cnt_reg;
        dv_next         = rd_en;
        didx_next       = rd_addr;
        item_next       = item_reg;
        req_ok_next     = req_ok_reg;
        req_idx_next    = req_idx_reg;
        req_free_next   = req_free_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_pkt_next  = found_pkt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_pkt_next   = best_pkt_reg;
        best_ret_next   = best_ret_reg;

        if (state_reg == rtt_pkg::ST_CLEAR) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // New request: latch it and restart the sweep
        if (accept) begin
            item_next       = s_data;
            req_ok_next     = (req_ext != '0) && (req_ext <= SLOTS_SW);
            req_idx_next    = IDXW'(req_ext - SW'(1));
            req_free_next   = 1'b0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            best_found_next = 1'b0;
            cnt_next        = '0;
        end

        if (rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // One row per cycle through the comparator
        if (state_reg == rtt_pkg::ST_SCAN && dv_reg) begin
            if (!is_check && rd_row.valid && cmp_eq && !found_reg) begin
                found_next     = 1'b1;
                found_idx_next = didx_reg;
                found_pkt_next = rd_row.packet;
            end
            if (!rd_row.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = didx_reg;
            end
            if (didx_reg == req_idx_reg) begin
                req_free_next = !rd_row.valid;
            end
            // Strictly earlier deadline wins, so ties keep the lowest slot
            if (is_check && rd_row.valid && (!best_found_reg || cmp_lt)) begin
                best_found_next = 1'b1;
                best_idx_next   = didx_reg;
                best_dl_next    = rd_row.deadline;
                best_pkt_next   = rd_row.packet;
                best_ret_next   = rd_row.retries;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtt_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
        end
    end

    // Sweep registers
    always_ff @(posedge aclk) begin
        didx_reg       <= didx_next;
        item_reg       <= item_next;
        req_ok_reg     <= req_ok_next;
        req_idx_reg    <= req_idx_next;
        req_free_reg   <= req_free_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_pkt_reg  <= found_pkt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_dl_reg    <= best_dl_next;
        best_pkt_reg   <= best_pkt_next;
        best_ret_reg   <= best_ret_next;
    end

    // Checks
    a_accept_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == rtt_pkg::ST_SCAN)
        else $error("request accepted without starting a sweep");

    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rtt_pkg::ST_SCAN |-> we == '0)
        else $error("table written during sweep");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && !res.hit |-> res.slot == '0 && res.packet_index_res == '0 && !res.gave_up)
        else $error("miss result carries nonzero fields");

    a_give_up_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.gave_up |-> res.hit && we.valid && !wr_row.valid)
        else $error("give-up without freeing the entry");

    a_not_ready_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rtt_pkg::ST_CLEAR |-> !s_ready && !rd_en)
        else $error("request taken during table clear");

endmodule

`default_nettype wire

// ===== design/request_retransmit_tracker_unit.sv =====
// A new request is taken only once the previous one has loaded its
// response; every request sweeps the whole table through its single read
// port, one slot per cycle.
// Reset: aresetn (synchronous, active low) restores timeout and retry_limit and
// starts a clearing pass over the slot valid bits; requests are taken once
// it completes, register writes at any time.
`default_nettype none

module request_retransmit_tracker_unit #(
    parameter int TABLE_SLOTS = rtt_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rtt_pkg::req_t                     s_data,
    // Response channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rtt_pkg::rsp_t                          m_data,
    // APB register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rtt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rtt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rtt_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic [rtt_pkg::TMO_W-1:0]   timeout_reg;
    logic [rtt_pkg::RETRY_W-1:0] retry_limit_reg;
    logic                        m_valid_reg;
    rtt_pkg::rsp_t               m_data_reg;
    logic                        out_free;
    logic                        res_load;
    rtt_pkg::rsp_t               res;
    logic                        reg_sel;

    // Register index is the 8-byte word address
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= rtt_pkg::TIMEOUT_RST;
            retry_limit_reg <= rtt_pkg::RETRY_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                rtt_pkg::REG_TIMEOUT:     timeout_reg     <= pwdata[rtt_pkg::TMO_W-1:0];
                rtt_pkg::REG_RETRY_LIMIT: retry_limit_reg <= pwdata[rtt_pkg::RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_sel)
            rtt_pkg::REG_TIMEOUT:
                prdata = {{(rtt_pkg::APB_DATA_W - rtt_pkg::TMO_W){1'b0}}, timeout_reg};
            rtt_pkg::REG_RETRY_LIMIT:
                prdata = {{(rtt_pkg::APB_DATA_W - rtt_pkg::RETRY_W){1'b0}}, retry_limit_reg};
            default: prdata = '0;
        endcase
    end

    rtt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .timeout     (timeout_reg),
        .retry_limit (retry_limit_reg),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    // Response output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sim/request_retransmit_tracker_unit_tb.sv =====
`default_nettype none

module request_retransmit_tracker_unit_tb;

    localparam int TABLE_SLOTS = rtt_pkg::TABLE_SLOTS_DEF;
    localparam int CLK_PERIOD = 12;
    localparam logic [rtt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [rtt_pkg::TIME_W-1:0] TIME_TOP = {rtt_pkg::TIME_W{1'b1}};
    localparam logic [rtt_pkg::TIME_W-1:0] T_1S = 63'd1000000000;

    // Directed request with its expected response, where typed in
    typedef struct packed {
        rtt_pkg::req_t req;
        logic          fixed;
        rtt_pkg::rsp_t rsp;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    rtt_pkg::req_t                  s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    rtt_pkg::rsp_t                  m_data;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [rtt_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [rtt_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [rtt_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Shadow of the request table and registers
    logic                        trk_valid    [TABLE_SLOTS];
    logic [rtt_pkg::SEQ_W-1:0]   trk_seq      [TABLE_SLOTS];
    logic [rtt_pkg::PKT_W-1:0]   trk_packet   [TABLE_SLOTS];
    logic [rtt_pkg::TIME_W-1:0]  trk_deadline [TABLE_SLOTS];
    logic [rtt_pkg::RETRY_W-1:0] trk_retries  [TABLE_SLOTS];
    logic [rtt_pkg::TMO_W-1:0]   cfg_timeout = rtt_pkg::TIMEOUT_RST;
    logic [rtt_pkg::RETRY_W-1:0] cfg_retry_limit = rtt_pkg::RETRY_LIMIT_RST;

    rtt_pkg::rsp_t expected_responses [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    logic [rtt_pkg::TIME_W-1:0] time_base = '0;
    logic [8:0]    stall_cycle = '0;
    logic [1:0]    stall_mode = '0;

    request_retransmit_tracker_unit #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #(CLK_PERIOD * 4000000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [rtt_pkg::TIME_W-1:0] random_word63();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[rtt_pkg::TIME_W-1:0];
    endfunction

    // now + timeout, clamped at the top of the time range
    function automatic logic [rtt_pkg::TIME_W-1:0] deadline_after(
        input logic [rtt_pkg::TIME_W-1:0] t);
        logic [rtt_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + {{(rtt_pkg::TIME_W + 1 - rtt_pkg::TMO_W){1'b0}}, cfg_timeout};
        return sum[rtt_pkg::TIME_W] ? TIME_TOP : sum[rtt_pkg::TIME_W-1:0];
    endfunction

    function automatic int find_entry(input logic [rtt_pkg::SEQ_W-1:0] seq);
        int pos;
        pos = -1;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (trk_valid[i] && trk_seq[i] == seq) pos = i;
        return pos;
    endfunction

    // Expected response for one request; updates the shadow table
    function automatic rtt_pkg::rsp_t predict_response(input rtt_pkg::req_t r);
        rtt_pkg::rsp_t rsp;
        int            pos;
        rsp = '0;
        pos = -1;
        if (r.kind == rtt_pkg::KIND_SAVE) begin
            if (find_entry(r.seq_num) < 0) begin
                if (r.slot_request == 0) begin
                    for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                        if (!trk_valid[i]) pos = i;
                end else if (r.slot_request <= TABLE_SLOTS &&
                             !trk_valid[int'(r.slot_request) - 1]) begin
                    pos = int'(r.slot_request) - 1;
                end
                if (pos >= 0) begin
                    trk_valid[pos]    = 1'b1;
                    trk_seq[pos]      = r.seq_num;
                    trk_packet[pos]   = r.packet_index;
                    trk_deadline[pos] = deadline_after(r.now);
                    trk_retries[pos]  = cfg_retry_limit;
                    rsp.hit  = 1'b1;
                    rsp.slot = rtt_pkg::SLOT_W'(pos + 1);
                end
            end
        end else if (r.kind == rtt_pkg::KIND_MATCH) begin
            pos = find_entry(r.seq_num);
            if (pos >= 0) begin
                trk_valid[pos] = 1'b0;
                rsp.hit = 1'b1;
                rsp.slot = rtt_pkg::SLOT_W'(pos + 1);
                rsp.packet_index_res = trk_packet[pos];
            end
        end else if (r.kind == rtt_pkg::KIND_CHECK) begin
            // earliest deadline, lowest slot on a tie
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (trk_valid[i] && (pos < 0 || trk_deadline[i] < trk_deadline[pos]))
                    pos = i;
            if (pos >= 0 && r.now >= trk_deadline[pos]) begin
                rsp.hit = 1'b1;
                rsp.slot = rtt_pkg::SLOT_W'(pos + 1);
                rsp.packet_index_res = trk_packet[pos];
                if (trk_retries[pos] == 0) begin
                    trk_valid[pos] = 1'b0;
                    rsp.gave_up = 1'b1;
                end else begin
                    trk_retries[pos]  = trk_retries[pos] - 1'b1;
                    trk_deadline[pos] = deadline_after(r.now);
                end
            end
        end
        return rsp;
    endfunction

    function automatic void add_row(input logic [rtt_pkg::KIND_W-1:0] kind,
                                    input logic [rtt_pkg::SEQ_W-1:0] seq,
                                    input logic [rtt_pkg::PKT_W-1:0] pkt,
                                    input logic [rtt_pkg::TIME_W-1:0] t,
                                    input logic [rtt_pkg::SLOT_W-1:0] slot_req,
                                    input logic fixed,
                                    input logic hit,
                                    input logic [rtt_pkg::SLOT_W-1:0] slot,
                                    input logic [rtt_pkg::PKT_W-1:0] pkt_res,
                                    input logic gave);
        stim_row_t row;
        row.req.kind = kind;
        row.req.seq_num = seq;
        row.req.packet_index = pkt;
        row.req.now = t;
        row.req.slot_request = slot_req;
        row.fixed = fixed;
        row.rsp.hit = hit;
        row.rsp.slot = slot;
        row.rsp.packet_index_res = pkt_res;
        row.rsp.gave_up = gave;
        directed_rows.push_back(row);
    endfunction

    // Random request: matches mostly reuse live sequence numbers; the clock moves steadily
    function automatic rtt_pkg::req_t random_request(input int save_pct, input int match_pct);
        rtt_pkg::req_t r;
        int   roll;
        int   step_cap;
        int   live [$];
        r.kind = rtt_pkg::KIND_CHECK;
        r.seq_num = random_word63();
        r.packet_index = rtt_pkg::PKT_W'($urandom);
        r.slot_request = rtt_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS));
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (trk_valid[i]) live.push_back(i);
        roll = $urandom_range(0, 99);
        if (roll < save_pct) begin
            r.kind = rtt_pkg::KIND_SAVE;
            roll = $urandom_range(0, 99);
            if (roll < 10 && live.size() != 0)
                r.seq_num = trk_seq[live[$urandom_range(0, live.size() - 1)]];
            else if (roll < 15)
                r.seq_num = rtt_pkg::SEQ_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 60)
                r.slot_request = '0;
            else if (roll < 95)
                r.slot_request = rtt_pkg::SLOT_W'($urandom_range(1, TABLE_SLOTS));
            else
                r.slot_request = rtt_pkg::SLOT_W'($urandom_range(TABLE_SLOTS + 1, 127));
        end else if (roll < save_pct + match_pct) begin
            r.kind = rtt_pkg::KIND_MATCH;
            if ($urandom_range(0, 3) != 0 && live.size() != 0)
                r.seq_num = trk_seq[live[$urandom_range(0, live.size() - 1)]];
            else if ($urandom_range(0, 1) == 1)
                r.seq_num = rtt_pkg::SEQ_W'($urandom_range(0, 15));
        end
        // advance the clock by up to one timeout, with some wild values
        step_cap = (cfg_timeout > 2000) ? 2000 : int'(cfg_timeout);
        time_base = time_base + rtt_pkg::TIME_W'($urandom_range(0, step_cap));
        roll = $urandom_range(0, 99);
        if (roll < 8)
            r.now = random_word63();
        else if (roll < 10)
            r.now = TIME_TOP;
        else
            r.now = time_base;
        return r;
    endfunction

    // Send one request in bursts with random gaps; queue its expected response
    task automatic send_request(input rtt_pkg::req_t item, input logic fixed,
                                input rtt_pkg::rsp_t fixed_rsp);
        rtt_pkg::rsp_t predicted;
        int            gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 4) == 0)
                gap = 0;
            else if ($urandom_range(0, 1) == 1)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(5, 90);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_response(item);
        expected_responses.push_back(fixed ? fixed_rsp : predicted);
        burst_left--;
    endtask

    task automatic drain_responses();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_responses.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [rtt_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Idle the block, load both registers, then run random traffic
    task automatic run_phase(input logic [rtt_pkg::TMO_W-1:0] tmo,
                             input logic [rtt_pkg::RETRY_W-1:0] lim,
                             input int count, input int save_pct, input int match_pct);
        drain_responses();
        apb_write(rtt_pkg::REG_TIMEOUT, rtt_pkg::APB_DATA_W'(tmo));
        cfg_timeout = tmo;
        apb_write(rtt_pkg::REG_RETRY_LIMIT, rtt_pkg::APB_DATA_W'(lim));
        cfg_retry_limit = lim;
        repeat (count) send_request(random_request(save_pct, match_pct), 1'b0, '0);
    endtask

    // Response check and receiver stall pattern
    always @(posedge aclk) begin : response_monitor
        rtt_pkg::rsp_t want;
        if (m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $error("response with no request outstanding: %h", m_data);
                mismatch_count++;
            end else begin
                want = expected_responses.pop_front();
                if (m_data.hit !== want.hit) begin
                    $error("hit: expected %0h, got %0h", want.hit, m_data.hit);
                    mismatch_count++;
                end
                if (m_data.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_data.slot);
                    mismatch_count++;
                end
                if (m_data.packet_index_res !== want.packet_index_res) begin
                    $error("packet_index_res: expected %0h, got %0h",
                           want.packet_index_res, m_data.packet_index_res);
                    mismatch_count++;
                end
                if (m_data.gave_up !== want.gave_up) begin
                    $error("gave_up: expected %0h, got %0h", want.gave_up, m_data.gave_up);
                    mismatch_count++;
                end
            end
        end
        // stall mode is redrawn each time the stall counter wraps
        stall_cycle <= stall_cycle + 1'b1;
        if (stall_cycle == '1)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (stall_cycle[5:0] < 6'd6);
            default: m_ready <= (stall_cycle[7:0] < 8'd2);
        endcase
    end

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            trk_valid[i]    = 1'b0;
            trk_seq[i]      = '0;
            trk_packet[i]   = '0;
            trk_deadline[i] = '0;
            trk_retries[i]  = '0;
        end

        // Directed requests, run at the reset register values
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_MATCH, 63'd5, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_SAVE, 63'd0, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b1, 7'd1, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_SAVE, TIME_TOP, 20'hFFFFF, 63'd0, 7'd64,
                1'b1, 1'b1, 7'd64, 20'h0, 1'b0);
        // duplicate sequence, busy slot, slots past the table end
        add_row(rtt_pkg::KIND_SAVE, 63'd0, 20'h3, 63'd0, 7'd2,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_SAVE, 63'd7, 20'h3, 63'd0, 7'd64,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_SAVE, 63'd8, 20'h3, 63'd0, 7'd65,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_SAVE, 63'd9, 20'h3, 63'd0, 7'd127,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        // deadline saturates
        add_row(rtt_pkg::KIND_SAVE, 63'd10, 20'h12345, TIME_TOP, 7'd0,
                1'b1, 1'b1, 7'd2, 20'h0, 1'b0);
        // one tick early, then a tie between slots 1 and 64
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S - 1, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S, 7'd0,
                1'b1, 1'b1, 7'd1, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S, 7'd0,
                1'b1, 1'b1, 7'd64, 20'hFFFFF, 1'b0);
        add_row(rtt_pkg::KIND_MATCH, TIME_TOP, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b1, 7'd64, 20'hFFFFF, 1'b0);
        add_row(rtt_pkg::KIND_MATCH, TIME_TOP, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(KIND_UNUSED, 63'd0, 20'hFFFFF, TIME_TOP, 7'd1,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        // slot 1 burns its retries, then is dropped
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S * 2, 7'd0,
                1'b0, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S * 3, 7'd0,
                1'b0, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, T_1S * 4, 7'd0,
                1'b1, 1'b1, 7'd1, 20'h0, 1'b1);
        // saturated deadline is due only at the top of the range
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, TIME_TOP - 1, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, TIME_TOP, 7'd0,
                1'b1, 1'b1, 7'd2, 20'h12345, 1'b0);
        add_row(rtt_pkg::KIND_MATCH, 63'd10, 20'h0, 63'd0, 7'd0,
                1'b1, 1'b1, 7'd2, 20'h12345, 1'b0);
        add_row(rtt_pkg::KIND_CHECK, 63'd0, 20'h0, TIME_TOP, 7'd0,
                1'b1, 1'b0, 7'd0, 20'h0, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

        // Random traffic under several register settings
        run_phase(48'd1, 4'd0, 200, 45, 20);
        run_phase({rtt_pkg::TMO_W{1'b1}}, 4'd15, 200, 45, 25);
        run_phase(48'd50, 4'd15, 200, 50, 15);
        run_phase(48'd700, 4'd2, 250, 75, 10);
        run_phase(48'd1, 4'd15, 200, 40, 20);
        run_phase(rtt_pkg::TMO_W'($urandom_range(2, 2000)),
                  rtt_pkg::RETRY_W'($urandom_range(0, 15)), 200, 35, 35);

        drain_responses();
        repeat (TABLE_SLOTS + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
